FILE: hw/rtl/morse_pkg.sv
`default_nettype none

package morse_pkg;

   // ascii bounds of the keyed characters
   localparam logic [7:0] CHAR_DIGIT_LO  = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
   localparam logic [7:0] CHAR_LETTER_LO = 8'h41;
   localparam logic [7:0] CHAR_LETTER_HI = 8'h5A;
   // symbol number of 'A' (digits take symbols 0 to 9)
   localparam logic [7:0] LETTER_BASE    = 8'd10;

   localparam int unsigned NUM_SYMBOLS = 36;

   // length of the keying buffer, bounded by the 7-bit chunk index
   localparam int unsigned NUM_CHUNKS  = 110;

   typedef logic [5:0] sym_type;
   typedef logic [2:0] elem_cnt_type;
   typedef logic [4:0] dash_mask_type;
   typedef logic [1:0] upc_type;
   typedef logic [1:0] jump_type;

   // element count per symbol, digits then letters
   localparam elem_cnt_type CODE_LEN [NUM_SYMBOLS] = '{
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   // bit k set: element k (first sent is bit 0) is a dash
   localparam dash_mask_type CODE_DASH [NUM_SYMBOLS] = '{
      5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F,
      5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E, 5'h05,
      5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01, 5'h04, 5'h08,
      5'h06, 5'h09, 5'h0D, 5'h03
   };

   // micro-program step addresses
   localparam upc_type UPC_ON    = 2'd0;
   localparam upc_type UPC_OFF   = 2'd1;
   localparam upc_type UPC_CLOSE = 2'd2;
   localparam upc_type UPC_SPARE = 2'd3;

   // jump conditions
   localparam jump_type JMP_NEXT = 2'd0;  // fall through
   localparam jump_type JMP_DASH = 2'd1;  // to target while a dash needs more on-chunks
   localparam jump_type JMP_MORE = 2'd2;  // to target while elements remain
   localparam jump_type JMP_END  = 2'd3;  // character finished

   typedef struct packed {
      logic     tone_on;   // value of the emitted chunk
      logic     last;      // closing chunk of the character
      logic     rep_inc;   // 1: count on-chunk, 0: clear repeat count
      logic     elem_inc;  // advance to next element
      jump_type jump;
      upc_type  target;
   } ucode_word_type;

   // control store
   function automatic ucode_word_type ucode_rom(input upc_type upc);
      ucode_word_type w;
      w = '{tone_on: 1'b0, last: 1'b1, rep_inc: 1'b0, elem_inc: 1'b0,
            jump: JMP_END, target: UPC_ON};
      unique case (upc)
         UPC_ON: begin
            w = '{tone_on: 1'b1, last: 1'b0, rep_inc: 1'b1, elem_inc: 1'b0,
                  jump: JMP_DASH, target: UPC_ON};
         end
         UPC_OFF: begin
            w = '{tone_on: 1'b0, last: 1'b0, rep_inc: 1'b0, elem_inc: 1'b1,
                  jump: JMP_MORE, target: UPC_ON};
         end
         UPC_CLOSE: begin
            w = '{tone_on: 1'b0, last: 1'b1, rep_inc: 1'b0, elem_inc: 1'b0,
                  jump: JMP_END, target: UPC_ON};
         end
         default: begin
            w = '{tone_on: 1'b0, last: 1'b1, rep_inc: 1'b0, elem_inc: 1'b0,
                  jump: JMP_END, target: UPC_ON};
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/morse_id_keying_encoder.sv
`default_nettype none
// channel  | ports                                    | direction
// req      | req_valid req_stall req_char_code        | in (stall out)
//          | req_first_char                           |
// rsp      | rsp_valid rsp_stall rsp_chunk_on         | out (stall in)
//          | rsp_chunk_index rsp_last_of_char         |
//
// a character is taken, then one chunk per cycle is emitted by the
// micro-program while the output is not stalled, up to 21 chunks; the next
// character is taken the cycle after the last chunk is loaded into the output register.
// a character that meets a full buffer stops without a further transfer.
// skipped or uncounted characters are taken but give no transfer.
// reset is synchronous and clears the sequencer, the character and position counters and output valid.
// rsp_stall holds the sequencer on its current step with the chunk parked.

module morse_id_keying_encoder
   import morse_pkg::*;
#(
   parameter int unsigned MAX_ID_CHARS = 5
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_first_char,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_chunk_on,
   output logic [6:0]      rsp_chunk_index,
   output logic            rsp_last_of_char
);

   localparam int unsigned CW = $clog2(MAX_ID_CHARS + 1);
   localparam int unsigned PW = $clog2(NUM_CHUNKS + 1);
   localparam logic [CW-1:0] CHARS_LIMIT = CW'(MAX_ID_CHARS);
   localparam logic [PW-1:0] POS_LIMIT   = PW'(NUM_CHUNKS);
   localparam logic [PW-1:0] POS_FINAL   = PW'(NUM_CHUNKS - 1);

   logic            busy_ff, busy_in;
   upc_type         upc_ff, upc_in;
   logic [CW-1:0]   chars_ff, chars_in;
   logic [PW-1:0]   pos_ff, pos_in;
   elem_cnt_type    len_ff, len_in;
   dash_mask_type   dash_ff, dash_in;
   elem_cnt_type    elem_ff, elem_in;
   logic [1:0]      rep_ff, rep_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_on_ff, rsp_on_in;
   logic [6:0]      rsp_index_ff, rsp_index_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_xfer;
   logic            out_free;
   logic            step_go;
   logic            pos_full;
   logic [CW-1:0]   chars_base;
   logic [PW-1:0]   pos_base;
   logic            is_digit, is_letter;
   logic [7:0]      sym_wide;
   sym_type         sym;
   ucode_word_type  uw;
   logic            take_jump;
   logic [3:0]      elem_next;

   assign req_stall = busy_ff;
   assign req_xfer  = req_valid && !busy_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = busy_ff && out_free;
   assign pos_full  = (pos_ff == POS_LIMIT);

   // character decode
   assign is_digit  = (req_char_code >= CHAR_DIGIT_LO) && (req_char_code <= CHAR_DIGIT_HI);
   assign is_letter = (req_char_code >= CHAR_LETTER_LO) && (req_char_code <= CHAR_LETTER_HI);
   assign sym_wide  = is_digit ? (req_char_code - CHAR_DIGIT_LO)
                               : (req_char_code - CHAR_LETTER_LO + LETTER_BASE);
   assign sym       = sym_wide[5:0];
   assign chars_base = req_first_char ? '0 : chars_ff;
   assign pos_base   = req_first_char ? '0 : pos_ff;

   // control word fetch and branch condition
   assign uw        = ucode_rom(upc_ff);
   assign elem_next = {1'b0, elem_ff} + 4'd1;
   always_comb begin
      case (uw.jump)
         JMP_DASH: take_jump = dash_ff[elem_ff] && (rep_ff != 2'd2);
         JMP_MORE: take_jump = elem_next < {1'b0, len_ff};
         default:  take_jump = 1'b0;
      endcase
   end

   // sequencer and datapath
   always_comb begin
      busy_in      = busy_ff;
      upc_in       = upc_ff;
      chars_in     = chars_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      dash_in      = dash_ff;
      elem_in      = elem_ff;
      rep_in       = rep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_on_in    = rsp_on_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_xfer) begin
         chars_in = chars_base;
         pos_in   = pos_base;
         if (chars_base < CHARS_LIMIT) begin
            chars_in = chars_base + CW'(1);
            if (is_digit || is_letter) begin
               busy_in = 1'b1;
               upc_in  = UPC_ON;
               len_in  = CODE_LEN[sym];
               dash_in = CODE_DASH[sym];
               elem_in = '0;
               rep_in  = '0;
            end
         end
      end else if (step_go) begin
         if (pos_full) begin
            // buffer exhausted: drop the rest of the character
            busy_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_on_in    = uw.tone_on;
            rsp_index_in = pos_ff[6:0];
            rsp_last_in  = uw.last || (pos_ff == POS_FINAL);
            pos_in       = pos_ff + PW'(1);
            rep_in       = uw.rep_inc ? rep_ff + 2'd1 : 2'd0;
            if (uw.elem_inc) begin
               elem_in = elem_next[2:0];
            end
            if (uw.jump == JMP_END) begin
               busy_in = 1'b0;
            end else if (take_jump) begin
               upc_in = uw.target;
            end else begin
               upc_in = upc_ff + 2'd1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         upc_ff       <= UPC_ON;
         chars_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         chars_ff     <= chars_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and output payload
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      dash_ff      <= dash_in;
      elem_ff      <= elem_in;
      rep_ff       <= rep_in;
      rsp_on_ff    <= rsp_on_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_on     = rsp_on_ff;
   assign rsp_chunk_index  = rsp_index_ff;
   assign rsp_last_of_char = rsp_last_ff;

   // checks
   // element counter reaches the length only on the closing step
   a_elem_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (elem_ff <= len_ff))
      else $error("element counter beyond symbol length");

   // repeat count wraps to three only after the last dash chunk
   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (upc_ff == UPC_ON)) |-> (rep_ff != 2'd3))
      else $error("dash repeat count overran");

   a_last_ends_char: assert property (@(posedge clock) disable iff (reset)
      (step_go && !pos_full && uw.last) |=> !busy_ff)
      else $error("sequencer still busy after closing chunk");

   a_upc_valid: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (upc_ff != UPC_SPARE))
      else $error("micro-program counter on unused step");

endmodule

`default_nettype wire
